/* hw/rtl/alst_pkg.sv */
`default_nettype none

package alst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_WIDTH  = 48;
   localparam int IDX_WIDTH   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1);
   localparam int LEAK_WIDTH  = 7;

   localparam logic [LEAK_WIDTH-1:0] LEAK_MAX = {LEAK_WIDTH{1'b1}};

   // action codes
   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_FREE    = 3'd1;
   localparam logic [2:0] ACT_UNTRACK = 3'd2;
   localparam logic [2:0] ACT_FINISH  = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   // entry conditions
   localparam logic [1:0] COND_ALLOC = 2'd0;
   localparam logic [1:0] COND_FREED = 2'd1;
   localparam logic [1:0] COND_ERROR = 2'd2;
   localparam logic [1:0] COND_NONE  = 2'd3;

   // result status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_UNTRACKED = 3'd1;
   localparam logic [2:0] STAT_DOUBLE    = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_LEAK      = 3'd4;

   typedef struct packed {
      logic [2:0]            action;
      logic [ADDR_WIDTH-1:0] address;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [1:0]            entry_condition;
      logic [LEAK_WIDTH-1:0] leak_count;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] address;
      logic [1:0]            condition;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic scan_run;
      logic commit;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_scan;
      logic scan_done;
   } dp_stat_type;

endpackage

`default_nettype wire

/* hw/rtl/allocation_state_tracker.sv */
`default_nettype none

// Allocation state tracker: a table of TABLE_DEPTH heap block addresses, each
// tagged allocated, freed or error.
// Request channel: drive req_data (action, address) and raise start; the
// transfer happens at the edge where start is high and busy is low. busy stays
// high until the event is fully applied to the table.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_data
// (status, entry_condition, leak_count). The receiver cannot stall, so the
// result must be captured in that cycle; nothing is held back.
// From start transfer to strobe: allocate/free/untrack of a nonzero
// address and checked finish walk the whole table one slot per cycle through
// the table RAM read port. Null address allocate/free/untrack, clear and
// unused codes skip the walk and go straight from decode to commit.
// One event is taken at a time; start may be raised again in the cycle
// the strobe is shown.
// Reset empties the table at once (valid bits in flops); RAM contents of
// invalid slots are read by the scan but ignored, so no clearing pass is needed.

module allocation_state_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire alst_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output alst_pkg::rsp_type      rsp_data
);

   import alst_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   // sequencer: idle, decode, scan, commit
   alst_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .dp_stat (dp_stat),
      .busy    (busy),
      .cmd     (ctl_cmd)
   );

   // table, slot scan, update and result register
   alst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (ctl_cmd),
      .dp_stat    (dp_stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/alst_ram.sv */
`default_nettype none

module alst_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]                        wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]                        rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/alst_ctrl.sv */
`default_nettype none

module alst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire alst_pkg::dp_stat_type dp_stat,
   output logic                      busy,
   output alst_pkg::ctl_cmd_type     cmd
);

   import alst_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.scan_run = 1'b0;
      cmd.commit   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = dp_stat.need_scan ? S_SCAN : S_COMMIT;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (dp_stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/alst_dp.sv */
`default_nettype none

module alst_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire alst_pkg::req_type     req_data,
   input  wire alst_pkg::ctl_cmd_type cmd,
   output alst_pkg::dp_stat_type      dp_stat,
   output logic                       rsp_strobe,
   output alst_pkg::rsp_type          rsp_data
);

   import alst_pkg::*;

   // request
   req_type               req_ff, req_in;
   // scan pointer and read pipeline
   logic [CNT_WIDTH-1:0]  scan_ptr_ff, scan_ptr_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_WIDTH-1:0]  chk_idx_ff, chk_idx_in;
   // search results
   logic                  hit_ff, hit_in;
   logic [IDX_WIDTH-1:0]  hit_idx_ff, hit_idx_in;
   logic [1:0]            hit_cond_ff, hit_cond_in;
   logic                  free_ff, free_in;
   logic [IDX_WIDTH-1:0]  free_idx_ff, free_idx_in;
   logic [LEAK_WIDTH-1:0] leak_ff, leak_in;
   // table valid bits
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   // result register
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   // table memory
   logic                  ram_we;
   logic [IDX_WIDTH-1:0]  ram_waddr;
   entry_type             ram_wdata;
   logic                  ram_re;
   entry_type             ram_rdata;

   logic                  addr_null;
   logic                  ptr_live;
   logic                  slot_valid;
   logic [1:0]            new_cond;

   alst_ram #(
      .DATA_WIDTH ($bits(entry_type)),
      .DEPTH      (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (scan_ptr_ff[IDX_WIDTH-1:0]),
      .rd_data (ram_rdata)
   );

   assign addr_null  = (req_ff.address == '0);
   assign ptr_live   = (scan_ptr_ff < CNT_WIDTH'(TABLE_DEPTH));
   assign slot_valid = valid_ff[chk_idx_ff];
   assign ram_re     = cmd.scan_run && ptr_live;

   assign dp_stat.need_scan = (((req_ff.action == ACT_ALLOC) ||
                                (req_ff.action == ACT_FREE) ||
                                (req_ff.action == ACT_UNTRACK)) && !addr_null) ||
                              (req_ff.action == ACT_FINISH);
   assign dp_stat.scan_done = !ptr_live && !chk_vld_ff;

   always_comb begin
      req_in        = req_ff;
      scan_ptr_in   = scan_ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cond_in   = hit_cond_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      leak_in       = leak_ff;
      valid_in      = valid_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = hit_idx_ff;
      ram_wdata     = '{address: req_ff.address, condition: COND_ALLOC};
      new_cond      = COND_ALLOC;

      if (cmd.capture) begin
         req_in      = req_data;
         scan_ptr_in = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
         leak_in     = '0;
      end

      // one slot per cycle: issue a read, check the slot read last cycle
      if (ram_re) begin
         scan_ptr_in = scan_ptr_ff + CNT_WIDTH'(1);
         chk_vld_in  = 1'b1;
         chk_idx_in  = scan_ptr_ff[IDX_WIDTH-1:0];
      end
      if (chk_vld_ff) begin
         if (slot_valid && !hit_ff && (ram_rdata.address == req_ff.address)) begin
            hit_in      = 1'b1;
            hit_idx_in  = chk_idx_ff;
            hit_cond_in = ram_rdata.condition;
         end
         if (!slot_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         if (slot_valid && (ram_rdata.condition == COND_ALLOC) && (leak_ff != LEAK_MAX)) begin
            leak_in = leak_ff + LEAK_WIDTH'(1);
         end
      end

      if (cmd.commit) begin
         rsp_strobe_in          = 1'b1;
         rsp_in.status          = STAT_OK;
         rsp_in.entry_condition = COND_NONE;
         rsp_in.leak_count      = '0;
         case (req_ff.action)
            ACT_ALLOC: begin
               if (!addr_null) begin
                  if (hit_ff) begin
                     new_cond               = (hit_cond_ff == COND_ERROR) ? COND_ERROR
                                                                          : COND_ALLOC;
                     ram_we                 = 1'b1;
                     ram_waddr              = hit_idx_ff;
                     ram_wdata.condition    = new_cond;
                     rsp_in.entry_condition = new_cond;
                     if (new_cond == COND_ERROR) begin
                        rsp_in.status = STAT_DOUBLE;
                     end
                  end else if (free_ff) begin
                     ram_we                 = 1'b1;
                     ram_waddr              = free_idx_ff;
                     valid_in[free_idx_ff]  = 1'b1;
                     rsp_in.entry_condition = COND_ALLOC;
                  end else begin
                     rsp_in.status = STAT_FULL;
                  end
               end
            end
            ACT_FREE: begin
               if (!addr_null) begin
                  if (hit_ff) begin
                     new_cond               = (hit_cond_ff == COND_ALLOC) ? COND_FREED
                                                                          : COND_ERROR;
                     ram_we                 = 1'b1;
                     ram_waddr              = hit_idx_ff;
                     ram_wdata.condition    = new_cond;
                     rsp_in.entry_condition = new_cond;
                     if (new_cond == COND_ERROR) begin
                        rsp_in.status = STAT_DOUBLE;
                     end
                  end else begin
                     rsp_in.status = STAT_UNTRACKED;
                  end
               end
            end
            ACT_UNTRACK: begin
               if (!addr_null && hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
            end
            ACT_FINISH: begin
               valid_in          = '0;
               rsp_in.leak_count = leak_ff;
               if (leak_ff != '0) begin
                  rsp_in.status = STAT_LEAK;
               end
            end
            ACT_CLEAR: begin
               valid_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      scan_ptr_ff <= scan_ptr_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_cond_ff <= hit_cond_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      leak_ff     <= leak_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a matched slot stays valid while the scan runs
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_run && hit_ff) |-> valid_ff[hit_idx_ff])
      else $error("matched slot lost its valid bit during scan");

   // leaks reported only with leak status
   a_leak_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_ff.leak_count != '0)) |-> (rsp_ff.status == STAT_LEAK))
      else $error("nonzero leak count without leak status");

   // an entry condition comes only with ok or double status
   a_cond_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_ff.entry_condition != COND_NONE)) |->
      ((rsp_ff.status == STAT_OK) || (rsp_ff.status == STAT_DOUBLE)))
      else $error("entry condition with unexpected status");

   // a free slot found by the scan is really empty at commit
   a_free_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && free_ff) |-> !valid_ff[free_idx_ff])
      else $error("free slot marked valid");

endmodule

`default_nettype wire
